FILE: src/vt4_pkg.sv
// vt4_pkg: types, sizes and helper functions shared by the vertex transform pipeline
// no dependencies; every module of the block refers to it by scoped names
`timescale 1ns / 1ps

package vt4_pkg;

  localparam int CW        = 16;            // component width
  localparam int FB        = 12;            // fraction bits
  localparam int ROW_W     = 64;            // width of one matrix row register
  localparam int DIM       = 4;
  localparam int PROD_W    = 2 * CW;        // exact product width
  localparam int ACC_W     = 2 * CW + 3;    // four products plus rounding term
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 2'd3;

  typedef logic signed [CW-1:0]  comp_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef row_t [DIM-1:0]        mat_t;

  typedef struct packed {
    comp_t in_x;
    comp_t in_y;
    comp_t in_z;
    comp_t in_w;
    logic  last_in;
  } vt4_in_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic  saturated;
    logic  last_out;
  } vt4_out_t;

  // stage 1 -> stage 2: all sixteen products, prod[row][col]
  typedef struct packed {
    logic [DIM-1:0][DIM-1:0][PROD_W-1:0] prod;
    logic                                last;
  } prod_stage_t;

  // stage 2 -> stage 3: one rounded-up sum per row, before the shift
  typedef struct packed {
    logic [DIM-1:0][ACC_W-1:0] acc;
    logic                      last;
  } sum_stage_t;

  // column j of a packed row; bits beyond the register read as zero
  function automatic comp_t col(input row_t row, input int j);
    logic [CW-1:0] c;
    int            idx;
    for (int b = 0; b < CW; b++) begin
      idx = CW * j + b;
      c[b] = (idx < ROW_W) ? row[idx % ROW_W] : 1'b0;
    end
    return comp_t'(c);
  endfunction

  // identity row i: 1.0 on the diagonal, clipped to the register
  function automatic row_t row_reset(input int i);
    logic [CW-1:0] one;
    row_t          r;
    int            idx;
    one = CW'(64'(1) << FB);
    r   = '0;
    for (int b = 0; b < CW; b++) begin
      idx = CW * i + b;
      if (idx < ROW_W) begin
        r[idx % ROW_W] = one[b];
      end
    end
    return r;
  endfunction

endpackage

FILE: src/vt4_mult_stage.sv
// vt4_mult_stage: first pipeline stage, forms all sixteen row-by-component products
// depends on vt4_pkg
`timescale 1ns / 1ps

module vt4_mult_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  vt4_pkg::vt4_in_t     up_data,
  output logic                 up_ready,
  input  vt4_pkg::mat_t        matrix,
  output logic                 dn_valid,
  output vt4_pkg::prod_stage_t dn_data,
  input  logic                 dn_ready
);

  logic                 valid_r;
  vt4_pkg::prod_stage_t data_r;
  vt4_pkg::prod_stage_t data_nxt;
  vt4_pkg::comp_t [vt4_pkg::DIM-1:0] vec;

  assign vec[0] = up_data.in_x;
  assign vec[1] = up_data.in_y;
  assign vec[2] = up_data.in_z;
  assign vec[3] = up_data.in_w;

  always_comb begin
    logic signed [vt4_pkg::PROD_W-1:0] p;
    logic signed [vt4_pkg::CW-1:0]     a;
    logic signed [vt4_pkg::CW-1:0]     b;
    data_nxt.last = up_data.last_in;
    data_nxt.prod = '0;
    for (int i = 0; i < vt4_pkg::DIM; i++) begin
      for (int j = 0; j < vt4_pkg::DIM; j++) begin
        a = vt4_pkg::col(matrix[i], j);
        b = vec[j];
        p = a * b;
        data_nxt.prod[i][j] = p;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: src/vt4_sum_stage.sv
// vt4_sum_stage: second pipeline stage, adds the four products of each row and the rounding term
// depends on vt4_pkg
`timescale 1ns / 1ps

module vt4_sum_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  vt4_pkg::prod_stage_t up_data,
  output logic                 up_ready,
  output logic                 dn_valid,
  output vt4_pkg::sum_stage_t  dn_data,
  input  logic                 dn_ready
);

  localparam logic [vt4_pkg::ACC_W-1:0] HALF_LSB =
    vt4_pkg::ACC_W'(1) << (vt4_pkg::FB - 1);

  logic                valid_r;
  vt4_pkg::sum_stage_t data_r;
  vt4_pkg::sum_stage_t data_nxt;

  always_comb begin
    logic signed [vt4_pkg::ACC_W-1:0] s;
    data_nxt.last = up_data.last;
    data_nxt.acc  = '0;
    for (int i = 0; i < vt4_pkg::DIM; i++) begin
      s = $signed(HALF_LSB);
      for (int j = 0; j < vt4_pkg::DIM; j++) begin
        s = s + vt4_pkg::ACC_W'($signed(up_data.prod[i][j]));
      end
      data_nxt.acc[i] = s;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: src/vt4_round_stage.sv
// vt4_round_stage: last pipeline stage, drops the fraction, clamps to component range, output register
// depends on vt4_pkg
`timescale 1ns / 1ps

module vt4_round_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  vt4_pkg::sum_stage_t up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output vt4_pkg::vt4_out_t   dn_data,
  input  logic                dn_ready
);

  localparam int SH_W = vt4_pkg::ACC_W - vt4_pkg::FB;

  logic              valid_r;
  vt4_pkg::vt4_out_t data_r;
  vt4_pkg::vt4_out_t data_nxt;
  vt4_pkg::comp_t [vt4_pkg::DIM-1:0] res;
  logic [vt4_pkg::DIM-1:0] clip;

  always_comb begin
    logic [SH_W-1:0] q;
    logic [SH_W-vt4_pkg::CW:0] top;
    for (int i = 0; i < vt4_pkg::DIM; i++) begin
      // floor shift of the biased sum gives round to nearest, ties up
      q   = up_data.acc[i][vt4_pkg::ACC_W-1:vt4_pkg::FB];
      top = q[SH_W-1:vt4_pkg::CW-1];
      clip[i] = !((&top) || !(|top));
      if (clip[i]) begin
        res[i] = q[SH_W-1] ? {1'b1, {(vt4_pkg::CW-1){1'b0}}}
                           : {1'b0, {(vt4_pkg::CW-1){1'b1}}};
      end else begin
        res[i] = q[vt4_pkg::CW-1:0];
      end
    end
    data_nxt.out_x     = res[0];
    data_nxt.out_y     = res[1];
    data_nxt.out_z     = res[2];
    data_nxt.out_w     = res[3];
    data_nxt.saturated = |clip;
    data_nxt.last_out  = up_data.last;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: src/vertex_transform_4x4_unit.sv
// vertex_transform_4x4_unit: top level, matrix row registers and the three-stage pipeline
// depends on vt4_pkg, vt4_mult_stage, vt4_sum_stage, vt4_round_stage
`timescale 1ns / 1ps

// Multiplies each vector (x, y, z, w) by a 4x4 signed Q3.12 matrix and returns the four
// dot products rounded to nearest (ties up) and clamped to 16 bits, with a flag when any
// component was clamped and the batch marker copied through. One vector is taken per
// clock while in_stall is low; its result is registered in turn by the multiply, add,
// round and clamp stages, the last of which is the output register. Each stage holds
// while the one after it is full and stalled, so in_stall follows out_stall only when
// the pipeline is full. Matrix rows reset to identity and are written through
// cfg_we/cfg_index/cfg_wdata, column j in bits 16j+15:16j; write them only while no
// vector is in flight.
module vertex_transform_4x4_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  vt4_pkg::vt4_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output vt4_pkg::vt4_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vt4_pkg::ROW_W-1:0]           cfg_wdata
);

  vt4_pkg::mat_t        rows_r;
  logic                 s1_ready;
  logic                 s1_valid;
  vt4_pkg::prod_stage_t s1_data;
  logic                 s2_ready;
  logic                 s2_valid;
  vt4_pkg::sum_stage_t  s2_data;
  logic                 s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vt4_pkg::DIM; i++) begin
        rows_r[i] <= vt4_pkg::row_reset(i);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        vt4_pkg::REG_ROW0: rows_r[0] <= cfg_wdata;
        vt4_pkg::REG_ROW1: rows_r[1] <= cfg_wdata;
        vt4_pkg::REG_ROW2: rows_r[2] <= cfg_wdata;
        vt4_pkg::REG_ROW3: rows_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vt4_mult_stage u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (s1_ready),
    .matrix   (rows_r),
    .dn_valid (s1_valid),
    .dn_data  (s1_data),
    .dn_ready (s2_ready)
  );

  vt4_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_data  (s1_data),
    .up_ready (s2_ready),
    .dn_valid (s2_valid),
    .dn_data  (s2_data),
    .dn_ready (s3_ready)
  );

  vt4_round_stage u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_data  (s2_data),
    .up_ready (s3_ready),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (!out_stall)
  );

  assign in_stall = !s1_ready;

endmodule
